// File: hw/rtl/edmf_pkg.sv
// Shared types, sizes and helper functions for the echo distance median filter.
package edmf_pkg;

	localparam int WINDOW    = 5;
	localparam int AGE_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int IDX_W     = AGE_W;
	localparam int CNT_W     = $clog2(WINDOW + 1);

	localparam int ECHO_W    = 16;
	localparam int SPEED_W   = 16;
	localparam int ZERO_W    = 12;
	localparam int MAXD_W    = 13;
	localparam int DIST_W    = 15;
	localparam int FILL_W    = 6;
	localparam int REG_IDX_W = 2;
	localparam int CFG_W     = 16;

	localparam int SAMP_W    = 20;
	localparam int POS_W     = 19;
	localparam int PROD_W    = ECHO_W + SPEED_W;
	localparam int DIV_SHIFT = 7;
	localparam int RECIP_W   = 26;
	localparam int QUOT_W    = 19;
	localparam int RFULL_W   = PROD_W - DIV_SHIFT + RECIP_W;
	localparam int GATE_W    = 24;

	// ceil(2^32 / 125); exact quotient for any 25-bit dividend
	localparam logic [RECIP_W-1:0] RECIP_K = 26'd34359739;
	localparam logic signed [SAMP_W-1:0] LO_GATE = -20'sd320;

	localparam logic [SPEED_W-1:0] SPEED_RST = 16'd43904;
	localparam logic [ZERO_W-1:0]  ZERO_RST  = 12'd0;
	localparam logic [MAXD_W-1:0]  MAXD_RST  = 13'd4000;

	localparam logic [REG_IDX_W-1:0] REG_SPEED = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_ZERO  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_MAXD  = 2'd2;

	localparam logic [AGE_W-1:0] AGE_LAST = AGE_W'(WINDOW - 1);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW - 1);
	localparam logic [CNT_W-1:0] RND_LAST = CNT_W'(WINDOW - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW);

	localparam logic [1:0] RANK_EMPTY  = 2'd0;
	localparam logic [1:0] RANK_NONPOS = 2'd1;
	localparam logic [1:0] RANK_POS    = 2'd2;

	typedef struct packed {
		logic                     valid;
		logic [AGE_W-1:0]         age;
		logic signed [SAMP_W-1:0] val;
	} entry_t;

	typedef struct packed {
		logic                     insert;
		logic                     sort;
		logic                     phase;
		logic                     full;
		logic [CNT_W-1:0]         count;
		logic signed [SAMP_W-1:0] sample;
	} cell_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_INSERT,
		ST_SORT,
		ST_MEDIAN,
		ST_FINISH
	} state_t;

	function automatic logic [1:0] ent_rank(input entry_t e);
		logic [1:0] r;
		if (!e.valid) begin
			r = RANK_EMPTY;
		end else if (e.val > 0) begin
			r = RANK_POS;
		end else begin
			r = RANK_NONPOS;
		end
		return r;
	endfunction

	// a belongs nearer cell 0 than b: positives descending, then other samples, then empty
	function automatic logic ent_before(input entry_t a, input entry_t b);
		logic [1:0] ra;
		logic [1:0] rb;
		ra = ent_rank(a);
		rb = ent_rank(b);
		return (ra > rb) || (ra == RANK_POS && rb == RANK_POS && a.val > b.val);
	endfunction

endpackage

// File: hw/rtl/edmf_conv.sv
// Echo time to 1/16 mm sample conversion pipeline with offset and range gate.
module edmf_conv import edmf_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     op,
	input  logic [ECHO_W-1:0]        echo_us,
	input  logic [SPEED_W-1:0]       speed,
	input  logic signed [ZERO_W-1:0] zero,
	input  logic [MAXD_W-1:0]        max_dist,
	output logic                     done,
	output logic signed [SAMP_W-1:0] sample,
	output logic                     keep,
	output logic                     pos
);

	logic                     vld_s1, vld_s2, vld_s3;
	logic                     op_s1, op_s2;
	logic [PROD_W-1:0]        prod_s1;
	logic [QUOT_W-1:0]        quot_s2;
	logic signed [SAMP_W-1:0] samp_s3;
	logic                     keep_s3;

	logic [RFULL_W-1:0]       recip_full;
	logic signed [SAMP_W-1:0] quot_ext, off16, samp_c;
	logic signed [GATE_W-1:0] samp_w, five_s, lim;
	logic                     lo_ok, hi_ok;

	// floor(p / 16000) = floor(floor(p / 128) / 125)
	assign recip_full = {{RECIP_W{1'b0}}, prod_s1[PROD_W-1:DIV_SHIFT]}
		* {{(PROD_W - DIV_SHIFT){1'b0}}, RECIP_K};

	always_comb begin
		quot_ext = $signed({1'b0, quot_s2});
		off16    = {{(SAMP_W - ZERO_W - 4){zero[ZERO_W-1]}}, zero, 4'b0000};
		samp_c   = op_s2 ? quot_ext : (quot_ext - off16);
		samp_w   = GATE_W'(samp_c);
		five_s   = (samp_w <<< 2) + samp_w;
		lim      = $signed(GATE_W'({max_dist, 6'b0}) + GATE_W'({max_dist, 5'b0}));
		lo_ok    = samp_c >= LO_GATE;
		hi_ok    = five_s <= lim;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod_s1 <= PROD_W'(echo_us) * PROD_W'(speed);
			op_s1   <= op;
		end
		if (vld_s1) begin
			quot_s2 <= recip_full[RFULL_W-1:RFULL_W-QUOT_W];
			op_s2   <= op_s1;
		end
		if (vld_s2) begin
			samp_s3 <= samp_c;
			keep_s3 <= op_s2 | (lo_ok & hi_ok);
		end
	end

	assign done   = vld_s3;
	assign sample = samp_s3;
	assign keep   = keep_s3;
	assign pos    = samp_s3 > 0;

endmodule

// File: hw/rtl/edmf_cell.sv
// One window cell: holds a sample and its age, inserts and swaps with a neighbor.
module edmf_cell import edmf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] idx,
	input  cell_ctrl_t       ctrl,
	input  entry_t           below,
	input  entry_t           above,
	output entry_t           ent,
	output logic             evict_pos
);

	entry_t ent_q, nxt;
	logic   is_low, has_mate, swap, hit;

	always_comb begin
		is_low   = (idx[0] == ctrl.phase);
		has_mate = is_low ? (idx != IDX_LAST) : (idx != '0);
		swap     = 1'b0;
		if (has_mate) begin
			swap = is_low ? ent_before(above, ent_q) : ent_before(ent_q, below);
		end
		hit = ctrl.full ? (ent_q.valid && ent_q.age == AGE_LAST)
			: (CNT_W'(idx) == ctrl.count);
		nxt = ent_q;
		if (ctrl.insert) begin
			if (hit) begin
				nxt.valid = 1'b1;
				nxt.age   = '0;
				nxt.val   = ctrl.sample;
			end else if (ent_q.valid) begin
				nxt.age = ent_q.age + 1'b1;
			end
		end else if (ctrl.sort && swap) begin
			nxt = is_low ? above : below;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else begin
			ent_q <= nxt;
		end
	end

	assign ent       = ent_q;
	assign evict_pos = ent_q.valid && ent_q.age == AGE_LAST && ent_q.val > 0;

endmodule

// File: hw/rtl/echo_distance_median_filter_unit.sv
// Echo distance median filter top level: config registers, sequencer, cell row, median.
//
// Sample channel: sample_valid / sample_stall with op and echo_us. A transfer
// happens when sample_valid is high and sample_stall is low. One sample is in
// work at a time; sample_stall is high from the transfer until its result is
// stored in the output register.
// Result channel: result_valid / result_stall with distance_mm, accepted and
// filled. The result register holds while result_stall is high, and the next
// sample may already be taken in; its result waits until the register frees.
// From sample transfer to result_valid, a sample passes the three-stage
// conversion pipeline and WINDOW odd-even exchange passes along the cell row
// that re-sort the window after each insert; the next sample is taken only
// once this result is stored in the output register.
// Configuration: cfg_we with cfg_index and cfg_data, to be written only while idle; the block does not enforce this.
// Reset clears the window, the counters and the result valid flag, and loads
// the default sound speed, zero offset and range.
module echo_distance_median_filter_unit import edmf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  logic                 op,
	input  logic [ECHO_W-1:0]    echo_us,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic [DIST_W-1:0]    distance_mm,
	output logic                 accepted,
	output logic [FILL_W-1:0]    filled
);

	state_t state_q, state_nxt;

	logic [SPEED_W-1:0]       speed_q;
	logic signed [ZERO_W-1:0] zero_q;
	logic [MAXD_W-1:0]        maxd_q;

	logic [CNT_W-1:0] count_q, npos_q, rnd_q;
	logic             full;

	logic                     conv_start, conv_done, conv_keep, conv_pos;
	logic signed [SAMP_W-1:0] conv_sample;

	cell_ctrl_t       ctrl;
	entry_t           ent [WINDOW];
	logic [WINDOW-1:0] evict_vec;
	logic             evict_any;

	logic             do_insert, do_sort, do_median, load;
	logic [CNT_W-1:0] hi_pos, lo_pos;
	logic [POS_W-1:0] med_a, med_b, med_a_q, med_b_q;
	logic [POS_W:0]   med_sum;
	logic [DIST_W-1:0] dist_c;

	logic              result_valid_q, accepted_q;
	logic [DIST_W-1:0] dist_q;
	logic [FILL_W-1:0] filled_q;

	logic [WINDOW-1:0] valid_vec, pos_vec, ordered;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= SPEED_RST;
			zero_q  <= ZERO_RST;
			maxd_q  <= MAXD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SPEED: speed_q <= cfg_data[SPEED_W-1:0];
				REG_ZERO:  zero_q  <= cfg_data[ZERO_W-1:0];
				REG_MAXD:  maxd_q  <= cfg_data[MAXD_W-1:0];
				default: ;
			endcase
		end
	end

	edmf_conv u_conv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (conv_start),
		.op       (op),
		.echo_us  (echo_us),
		.speed    (speed_q),
		.zero     (zero_q),
		.max_dist (maxd_q),
		.done     (conv_done),
		.sample   (conv_sample),
		.keep     (conv_keep),
		.pos      (conv_pos)
	);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:   if (sample_valid) state_nxt = ST_CONV;
			ST_CONV:   if (conv_done) state_nxt = ST_INSERT;
			ST_INSERT: state_nxt = ST_SORT;
			ST_SORT:   if (rnd_q == RND_LAST) state_nxt = ST_MEDIAN;
			ST_MEDIAN: state_nxt = ST_FINISH;
			ST_FINISH: if (!result_valid_q || !result_stall) state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		sample_stall = 1'b1;
		conv_start   = 1'b0;
		do_insert    = 1'b0;
		do_sort      = 1'b0;
		do_median    = 1'b0;
		load         = 1'b0;
		case (state_q)
			ST_IDLE: begin
				sample_stall = 1'b0;
				conv_start   = sample_valid;
			end
			ST_INSERT: do_insert = conv_keep;
			ST_SORT:   do_sort   = 1'b1;
			ST_MEDIAN: do_median = 1'b1;
			ST_FINISH: load      = !result_valid_q || !result_stall;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign full      = count_q == CNT_FULL;
	assign evict_any = |evict_vec;

	always_comb begin
		ctrl.insert = do_insert;
		ctrl.sort   = do_sort;
		ctrl.phase  = rnd_q[0];
		ctrl.full   = full;
		ctrl.count  = count_q;
		ctrl.sample = conv_sample;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			npos_q  <= '0;
			rnd_q   <= '0;
		end else begin
			if (do_insert) begin
				if (!full) count_q <= count_q + 1'b1;
				npos_q <= npos_q + CNT_W'(conv_pos) - CNT_W'(full & evict_any);
			end
			if (state_q == ST_INSERT) begin
				rnd_q <= '0;
			end else if (do_sort) begin
				rnd_q <= rnd_q + 1'b1;
			end
		end
	end

	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		entry_t below_w, above_w;
		if (i == 0) begin : g_lo
			assign below_w = '0;
		end else begin : g_lo
			assign below_w = ent[i-1];
		end
		if (i == WINDOW - 1) begin : g_hi
			assign above_w = '0;
		end else begin : g_hi
			assign above_w = ent[i+1];
		end
		edmf_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.idx       (IDX_W'(i)),
			.ctrl      (ctrl),
			.below     (below_w),
			.above     (above_w),
			.ent       (ent[i]),
			.evict_pos (evict_vec[i])
		);
	end

	// positives sit in cells 0..npos-1, descending
	assign hi_pos = npos_q >> 1;
	assign lo_pos = hi_pos - 1'b1;

	always_comb begin
		med_a = '0;
		med_b = '0;
		for (int i = 0; i < WINDOW; i++) begin
			if (CNT_W'(i) == hi_pos) med_a = med_a | ent[i].val[POS_W-1:0];
			if (CNT_W'(i) == lo_pos) med_b = med_b | ent[i].val[POS_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (do_median) begin
			med_a_q <= med_a;
			med_b_q <= med_b;
		end
	end

	always_comb begin
		med_sum = {1'b0, med_a_q} + {1'b0, med_b_q};
		if (npos_q == '0) begin
			dist_c = '0;
		end else if (npos_q[0]) begin
			dist_c = med_a_q[POS_W-1:4];
		end else begin
			dist_c = med_sum[POS_W:5];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dist_q     <= dist_c;
			accepted_q <= conv_keep;
			filled_q   <= FILL_W'(count_q);
		end
	end

	assign result_valid = result_valid_q;
	assign distance_mm  = dist_q;
	assign accepted     = accepted_q;
	assign filled       = filled_q;

	always_comb begin
		for (int i = 0; i < WINDOW; i++) begin
			valid_vec[i] = ent[i].valid;
			pos_vec[i]   = ent_rank(ent[i]) == RANK_POS;
		end
		for (int i = 0; i < WINDOW - 1; i++) begin
			ordered[i] = !ent_before(ent[i+1], ent[i]);
		end
		ordered[WINDOW-1] = 1'b1;
	end

	a_cnt_match: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == count_q)
		else $error("window count disagrees with occupied cells");

	a_pos_match: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(pos_vec) == npos_q)
		else $error("positive count disagrees with cell contents");

	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MEDIAN) |-> (&ordered))
		else $error("cell row not sorted at median pick");

	a_conv_when: assert property (@(posedge clk) disable iff (!arst_n)
		conv_done |-> (state_q == ST_CONV))
		else $error("conversion finished outside conversion wait");

endmodule

// File: test/edmf_tb_pkg.sv
// Operation codes, spare register index and result record for the echo filter testbench.
package edmf_tb_pkg;
	import edmf_pkg::*;

	localparam logic OP_FILTERED = 1'b0;
	localparam logic OP_CALIB    = 1'b1;

	// no register behind this index; writes to it must be ignored
	localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic [DIST_W-1:0] dist_mm;
		logic              acc;
		logic [FILL_W-1:0] fill;
	} reading_t;

endpackage

// File: test/echo_filter_checker.sv
// Checker for the echo distance median filter: tracks registers and window, compares results.
module echo_filter_checker import edmf_pkg::*, edmf_tb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 sample_valid,
	input  logic                 sample_stall,
	input  logic                 op,
	input  logic [ECHO_W-1:0]    echo_us,
	input  logic                 result_valid,
	input  logic                 result_stall,
	input  logic [DIST_W-1:0]    distance_mm,
	input  logic                 accepted,
	input  logic [FILL_W-1:0]    filled,
	output int                   mismatch_count,
	output int                   readings_due
);

	logic [SPEED_W-1:0]       speed_q8;
	logic signed [ZERO_W-1:0] zero_mm;
	logic [MAXD_W-1:0]        range_mm;
	logic signed [SAMP_W-1:0] ring [WINDOW];
	int                       ring_count;
	int                       ring_head;
	reading_t                 due_q [$];
	int                       errors;

	function automatic reading_t predict_reading(input logic op_code,
			input logic [ECHO_W-1:0] echo);
		longint   prod;
		int       samp;
		logic     keep;
		int       pos [WINDOW];
		int       n;
		int       v;
		int       i;
		int       j;
		reading_t r;
		prod = longint'(echo) * longint'(speed_q8);
		samp = int'(prod / 16000);
		keep = 1'b1;
		if (op_code == OP_FILTERED) begin
			samp = samp - 16 * int'(zero_mm);
			keep = (samp >= int'(LO_GATE)) && (longint'(samp) * 5 <= longint'(range_mm) * 96);
		end
		if (keep) begin
			if (ring_count < WINDOW) begin
				ring[(ring_head + ring_count) % WINDOW] = SAMP_W'(samp);
				ring_count++;
			end else begin
				ring[ring_head] = SAMP_W'(samp);
				ring_head = (ring_head + 1) % WINDOW;
			end
		end
		// sorted list of the positive samples only
		n = 0;
		for (i = 0; i < ring_count; i++) begin
			v = int'(ring[(ring_head + i) % WINDOW]);
			if (v > 0) begin
				j = n;
				while (j > 0 && pos[j - 1] > v) begin
					pos[j] = pos[j - 1];
					j--;
				end
				pos[j] = v;
				n++;
			end
		end
		if (n == 0) begin
			r.dist_mm = '0;
		end else if (n % 2 == 1) begin
			r.dist_mm = DIST_W'(pos[n / 2] / 16);
		end else begin
			r.dist_mm = DIST_W'((pos[n / 2 - 1] + pos[n / 2]) / 32);
		end
		r.acc  = keep;
		r.fill = FILL_W'(ring_count);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reading_t want;
		if (!arst_n) begin
			speed_q8   = SPEED_RST;
			zero_mm    = ZERO_RST;
			range_mm   = MAXD_RST;
			ring_count = 0;
			ring_head  = 0;
			errors     = 0;
			due_q.delete();
			mismatch_count <= 0;
			readings_due   <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (due_q.size() == 0) begin
					if (errors < 10) begin
						$display("echo filter: unexpected result dist %0d acc %0d fill %0d",
							distance_mm, accepted, filled);
					end
					errors++;
				end else begin
					want = due_q.pop_front();
					if (distance_mm !== want.dist_mm || accepted !== want.acc
							|| filled !== want.fill) begin
						if (errors < 10) begin
							$display({"echo filter mismatch: expected dist %0d acc %0d fill %0d,",
								" got dist %0d acc %0d fill %0d"}, want.dist_mm, want.acc,
								want.fill, distance_mm, accepted, filled);
						end
						errors++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_SPEED: speed_q8 = cfg_data[SPEED_W-1:0];
					REG_ZERO:  zero_mm  = cfg_data[ZERO_W-1:0];
					REG_MAXD:  range_mm = cfg_data[MAXD_W-1:0];
					default: ;
				endcase
			end
			if (sample_valid && !sample_stall) begin
				due_q.insert(due_q.size(), predict_reading(op, echo_us));
			end
			mismatch_count <= errors;
			readings_due   <= due_q.size();
		end
	end

endmodule

// File: test/tb_top.sv
// Testbench top for the echo distance median filter: stimulus, stalls and verdict.
module tb_top;
	import edmf_pkg::*;
	import edmf_tb_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 2 * WINDOW + 12;
	localparam int HOLD_CYCLES  = 90;
	localparam int PHASE_ITEMS  = 360;
	localparam int CFG_EVERY    = 120;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 cfg_we       = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index    = '0;
	logic [CFG_W-1:0]     cfg_data     = '0;
	logic                 sample_valid = 1'b0;
	logic                 sample_stall;
	logic                 op           = 1'b0;
	logic [ECHO_W-1:0]    echo_us      = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	logic [DIST_W-1:0]    distance_mm;
	logic                 accepted;
	logic [FILL_W-1:0]    filled;

	int mismatch_count;
	int readings_due;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int holds_asked = 0;
	int holds_done  = 0;
	int hold_left   = 0;
	int cycles      = 0;

	echo_distance_median_filter_unit u_top (
		.clk,
		.arst_n,
		.cfg_we,
		.cfg_index,
		.cfg_data,
		.sample_valid,
		.sample_stall,
		.op,
		.echo_us,
		.result_valid,
		.result_stall,
		.distance_mm,
		.accepted,
		.filled
	);

	echo_filter_checker u_checker (.*);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_top: errors");
		$finish;
	end

	// result side: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (holds_done != holds_asked) begin
			result_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			holds_done <= holds_asked;
		end else begin
			result_stall <= ($urandom_range(0, 99) < rx_idle_pct);
		end
	end

	task automatic send_echo(input logic op_code, input logic [ECHO_W-1:0] echo);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		op <= op_code;
		echo_us <= echo;
		do begin
			@(posedge clk);
		end while (sample_stall);
	endtask

	task automatic drain_results();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (readings_due != 0) @(posedge clk);
	endtask

	task automatic write_config(input logic [SPEED_W-1:0] speed,
			input logic [ZERO_W-1:0] zero, input logic [MAXD_W-1:0] maxd);
		cfg_we <= 1'b1;
		cfg_index <= REG_SPEED;
		cfg_data <= speed;
		@(posedge clk);
		cfg_index <= REG_ZERO;
		cfg_data <= {{(CFG_W - ZERO_W){zero[ZERO_W-1]}}, zero};
		@(posedge clk);
		cfg_index <= REG_MAXD;
		cfg_data <= CFG_W'(maxd);
		@(posedge clk);
		cfg_index <= REG_SPARE;
		cfg_data <= CFG_W'($urandom_range(0, 65535));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int                 ph;
		int                 k;
		int                 z;
		logic               op_code;
		logic [ECHO_W-1:0]  echo;
		logic [SPEED_W-1:0] speed;
		logic [MAXD_W-1:0]  maxd;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers: no echo, both sides of the upper gate, full range, window wrap
		send_echo(OP_FILTERED, 16'd0);
		send_echo(OP_CALIB, 16'd0);
		send_echo(OP_FILTERED, 16'd27988);
		send_echo(OP_FILTERED, 16'd27989);
		send_echo(OP_CALIB, 16'hFFFF);
		send_echo(OP_FILTERED, 16'hFFFF);
		send_echo(OP_CALIB, 16'd1);
		send_echo(OP_FILTERED, 16'd100);
		send_echo(OP_CALIB, 16'd5000);

		// offset lands exactly on the lower gate
		drain_results();
		write_config(16'hFFFF, ZERO_W'(20), 13'd8191);
		send_echo(OP_FILTERED, 16'd0);
		send_echo(OP_FILTERED, 16'hFFFF);
		send_echo(OP_CALIB, 16'hFFFF);
		send_echo(OP_FILTERED, 16'd1234);

		// one step below the lower gate, zero speed, zero range
		drain_results();
		write_config(16'd0, ZERO_W'(21), 13'd0);
		send_echo(OP_FILTERED, 16'd0);
		send_echo(OP_FILTERED, 16'hFFFF);
		send_echo(OP_CALIB, 16'd40000);
		send_echo(OP_CALIB, 16'd0);

		// most negative offset pushes filtered samples up
		drain_results();
		write_config(16'd1, ZERO_W'(-2048), 13'd8191);
		send_echo(OP_FILTERED, 16'hFFFF);
		send_echo(OP_FILTERED, 16'd0);
		send_echo(OP_CALIB, 16'hFFFF);

		for (ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					tx_idle_pct = 18;
					rx_idle_pct = 67;
				end
				1: begin
					tx_idle_pct = 67;
					rx_idle_pct = 18;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			for (k = 0; k < PHASE_ITEMS; k++) begin
				if (k % CFG_EVERY == 0) begin
					drain_results();
					case ($urandom_range(0, 3))
						0: speed = SPEED_W'($urandom_range(0, 65535));
						3: speed = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
						default: speed = SPEED_W'($urandom_range(40000, 48000));
					endcase
					if ($urandom_range(0, 3) == 0) begin
						z = int'($urandom_range(0, 4095)) - 2048;
					end else begin
						z = int'($urandom_range(0, 80)) - 40;
					end
					if ($urandom_range(0, 2) == 0) begin
						maxd = MAXD_W'($urandom_range(0, 8191));
					end else begin
						maxd = MAXD_W'($urandom_range(2000, 8191));
					end
					write_config(speed, ZERO_W'(z), maxd);
				end
				if (k == CFG_EVERY / 2) holds_asked++;
				// sender stops until everything is out, then resumes
				if (k == 2 * CFG_EVERY - 30) drain_results();
				case ($urandom_range(0, 9))
					0: echo = '0;
					1, 2: echo = ECHO_W'($urandom_range(0, 65535));
					default: echo = ECHO_W'($urandom_range(0, 30000));
				endcase
				op_code = ($urandom_range(0, 3) == 0) ? OP_CALIB : OP_FILTERED;
				send_echo(op_code, echo);
			end
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && readings_due == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/edmf_pkg.sv
hw/rtl/edmf_conv.sv
hw/rtl/edmf_cell.sv
hw/rtl/echo_distance_median_filter_unit.sv
test/edmf_tb_pkg.sv
test/echo_filter_checker.sv
test/tb_top.sv
